/* hdl/mfd_pkg.sv */
// ----------------------------------------------------------------------------
// mfd_pkg
// Shared constants, codes and controller/datapath interface types for the
// monochrome frame buffer draw engine.
// ----------------------------------------------------------------------------
package mfd_pkg;

  localparam int MAX_WIDTH     = 256;
  localparam int MAX_HEIGHT    = 256;
  localparam int ROW_BYTES_MAX = (MAX_WIDTH + 7) / 8;
  localparam int STORE_BYTES   = ROW_BYTES_MAX * MAX_HEIGHT;

  localparam int ADDR_W  = $clog2(STORE_BYTES);
  localparam int COUNT_W = ADDR_W + 1;
  localparam int EFFW_W  = $clog2(MAX_WIDTH + 1);
  localparam int EFFH_W  = $clog2(MAX_HEIGHT + 1);
  localparam int ROWB_W  = $clog2(ROW_BYTES_MAX + 1);

  localparam int ACTION_W = 3;
  localparam int POS_W    = 8;
  localparam int LEN_W    = 9;
  localparam int RSIZE_W  = 8;
  localparam int IDX_W    = 13;
  localparam int DATA_W   = 8;
  localparam int DIM_W    = 9;
  localparam int THICK_W  = 8;
  localparam int COORD_W  = 11;
  localparam int SEG_W    = 3;
  localparam int PROD_W   = COORD_W + ROWB_W;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 9;

  localparam int IN_FIELDS_W = 2 * POS_W + LEN_W + 2 * RSIZE_W + IDX_W;
  localparam int S_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int S_TUSER_W   = ACTION_W;
  localparam int M_TDATA_W   = DATA_W;

  localparam logic [DIM_W-1:0]   RST_FRAME_WIDTH  = DIM_W'(200);
  localparam logic [DIM_W-1:0]   RST_FRAME_HEIGHT = DIM_W'(200);
  localparam logic [THICK_W-1:0] RST_THICKNESS    = THICK_W'(1);
  localparam logic               RST_DRAW_COLOR   = 1'b1;

  localparam logic [DATA_W-1:0] PIXEL_MSB  = 8'h80;
  localparam logic [DATA_W-1:0] FILL_ONES  = 8'hFF;
  localparam logic [DATA_W-1:0] FILL_ZEROS = 8'h00;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PIXEL = 3'd0,
    ACT_HLINE = 3'd1,
    ACT_VLINE = 3'd2,
    ACT_RECT  = 3'd3,
    ACT_FILL  = 3'd4,
    ACT_READ  = 3'd5
  } action_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_FRAME_WIDTH    = 2'd0,
    CFG_FRAME_HEIGHT   = 2'd1,
    CFG_LINE_THICKNESS = 2'd2,
    CFG_DRAW_COLOR     = 2'd3
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_SEG,
    ST_SEG_CHECK,
    ST_PIX_CALC,
    ST_PIX_TEST,
    ST_PIX_WRITE,
    ST_FILL,
    ST_READ,
    ST_READ_WAIT,
    ST_RESULT
  } state_t;

  // Input fields packed from the lowest bit up.
  typedef struct packed {
    logic [IDX_W-1:0]   read_index;
    logic [RSIZE_W-1:0] rect_height;
    logic [RSIZE_W-1:0] rect_width;
    logic [LEN_W-1:0]   length;
    logic [POS_W-1:0]   y_pos;
    logic [POS_W-1:0]   x_pos;
  } in_fields_t;

  typedef struct packed {
    logic load;
    logic clear_write;
    logic fill_init;
    logic fill_write;
    logic seg_load;
    logic seg_next;
    logic pix_calc;
    logic mark_clip;
    logic step;
    logic pix_read;
    logic pix_write;
    logic idx_read;
    logic read_capture;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    action_t action;
    logic    clear_last;
    logic    fill_done;
    logic    seg_done;
    logic    seg_empty;
    logic    pix_outside;
    logic    pix_last;
    logic    out_free;
  } status_t;

endpackage

/* hdl/mfd_ctrl.sv */
// ----------------------------------------------------------------------------
// mfd_ctrl
// Command sequencer: clears the store after reset, then walks each command
// through its segments, pixels, fill bytes or read, and hands off the result.
// ----------------------------------------------------------------------------
module mfd_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  mfd_pkg::status_t status,
  output mfd_pkg::cmd_t    cmd
);
  import mfd_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (status.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_DECODE;
      end
      ST_DECODE: begin
        case (status.action)
          ACT_PIXEL, ACT_HLINE, ACT_VLINE, ACT_RECT: state_next = ST_SEG;
          ACT_FILL: state_next = ST_FILL;
          ACT_READ: state_next = ST_READ;
          default:  state_next = ST_RESULT;
        endcase
      end
      ST_SEG: begin
        state_next = status.seg_done ? ST_RESULT : ST_SEG_CHECK;
      end
      ST_SEG_CHECK: begin
        state_next = status.seg_empty ? ST_SEG : ST_PIX_CALC;
      end
      ST_PIX_CALC: begin
        state_next = ST_PIX_TEST;
      end
      ST_PIX_TEST: begin
        if (!status.pix_outside) begin
          state_next = ST_PIX_WRITE;
        end else begin
          state_next = status.pix_last ? ST_SEG : ST_PIX_CALC;
        end
      end
      ST_PIX_WRITE: begin
        state_next = status.pix_last ? ST_SEG : ST_PIX_CALC;
      end
      ST_FILL: begin
        if (status.fill_done) state_next = ST_RESULT;
      end
      ST_READ: begin
        state_next = ST_READ_WAIT;
      end
      ST_READ_WAIT: begin
        state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.clear_write = 1'b1;
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      ST_DECODE: begin
        cmd.fill_init = (status.action == ACT_FILL);
      end
      ST_SEG: begin
        cmd.seg_load = !status.seg_done;
      end
      ST_SEG_CHECK: begin
        cmd.seg_next = status.seg_empty;
      end
      ST_PIX_CALC: begin
        cmd.pix_calc = 1'b1;
      end
      ST_PIX_TEST: begin
        if (status.pix_outside) begin
          cmd.mark_clip = 1'b1;
          cmd.step      = 1'b1;
          cmd.seg_next  = status.pix_last;
        end else begin
          cmd.pix_read = 1'b1;
        end
      end
      ST_PIX_WRITE: begin
        cmd.pix_write = 1'b1;
        cmd.step      = 1'b1;
        cmd.seg_next  = status.pix_last;
      end
      ST_FILL: begin
        cmd.fill_write = !status.fill_done;
      end
      ST_READ: begin
        cmd.idx_read = 1'b1;
      end
      ST_READ_WAIT: begin
        cmd.read_capture = 1'b1;
      end
      ST_RESULT: begin
        cmd.out_load = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

/* hdl/mfd_datapath.sv */
// ----------------------------------------------------------------------------
// mfd_datapath
// Configuration registers, command registers, segment and pixel counters,
// address generation, the frame store memory and the result register.
// ----------------------------------------------------------------------------
module mfd_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [mfd_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [mfd_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [mfd_pkg::S_TDATA_W-1:0]    s_tdata,
  input  logic [mfd_pkg::S_TUSER_W-1:0]    s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [mfd_pkg::M_TDATA_W-1:0]    m_tdata,
  output logic                             m_tuser,
  input  mfd_pkg::cmd_t                    cmd,
  output mfd_pkg::status_t                 status
);
  import mfd_pkg::*;

  logic [DIM_W-1:0]   frame_width;
  logic [DIM_W-1:0]   frame_height;
  logic [THICK_W-1:0] line_thickness;
  logic               draw_color;

  action_t            cmd_action;
  in_fields_t         cmd_fields;
  in_fields_t         in_fields;

  logic [SEG_W-1:0]   seg;
  logic [SEG_W-1:0]   seg_count;
  logic [COORD_W-1:0] seg_x;
  logic [COORD_W-1:0] seg_y;
  logic [LEN_W-1:0]   seg_len;
  logic [THICK_W-1:0] seg_thick;
  logic               seg_horiz;
  logic [COORD_W-1:0] seg_x_next;
  logic [COORD_W-1:0] seg_y_next;
  logic [LEN_W-1:0]   seg_len_next;
  logic [THICK_W-1:0] seg_thick_next;
  logic               seg_horiz_next;

  logic [LEN_W-1:0]   cnt_a;
  logic [THICK_W-1:0] cnt_t;
  logic               thick_last;

  logic [EFFW_W-1:0]  eff_w;
  logic [EFFH_W-1:0]  eff_h;
  logic [ROWB_W-1:0]  row_bytes;
  logic [COORD_W-1:0] px;
  logic [COORD_W-1:0] py;
  logic [PROD_W-1:0]  lin_addr;
  logic               in_frame;

  logic [ADDR_W-1:0]  pix_addr;
  logic [DATA_W-1:0]  pix_mask;
  logic               pix_outside;

  logic [COUNT_W-1:0]        count;
  logic [COUNT_W-1:0]        fill_total;
  logic [ROWB_W+EFFH_W-1:0]  fill_prod;

  logic [DATA_W-1:0]  mem [STORE_BYTES];
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [DATA_W-1:0]  mem_wdata;
  logic               mem_re;
  logic [ADDR_W-1:0]  mem_raddr;
  logic [DATA_W-1:0]  mem_rdata;
  logic               idx_ok;

  logic               clip;
  logic [DATA_W-1:0]  rd_byte;

  assign in_fields = s_tdata[IN_FIELDS_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width    <= RST_FRAME_WIDTH;
      frame_height   <= RST_FRAME_HEIGHT;
      line_thickness <= RST_THICKNESS;
      draw_color     <= RST_DRAW_COLOR;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_FRAME_WIDTH:    frame_width    <= cfg_data[DIM_W-1:0];
        CFG_FRAME_HEIGHT:   frame_height   <= cfg_data[DIM_W-1:0];
        CFG_LINE_THICKNESS: line_thickness <= cfg_data[THICK_W-1:0];
        CFG_DRAW_COLOR:     draw_color     <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    eff_w     = (32'(frame_width) > MAX_WIDTH) ? EFFW_W'(MAX_WIDTH) : EFFW_W'(frame_width);
    eff_h     = (32'(frame_height) > MAX_HEIGHT) ? EFFH_W'(MAX_HEIGHT)
                                                 : EFFH_W'(frame_height);
    row_bytes = ROWB_W'(({1'b0, eff_w} + (EFFW_W+1)'(7)) >> 3);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_action <= action_t'(s_tuser);
      cmd_fields <= in_fields;
    end
  end

  // Segment list of the current command.
  always_comb begin
    seg_x_next     = COORD_W'(cmd_fields.x_pos);
    seg_y_next     = COORD_W'(cmd_fields.y_pos);
    seg_len_next   = cmd_fields.length;
    seg_thick_next = line_thickness;
    seg_horiz_next = 1'b1;
    seg_count      = '0;
    case (cmd_action)
      ACT_PIXEL: begin
        seg_len_next   = LEN_W'(1);
        seg_thick_next = THICK_W'(1);
        seg_count      = SEG_W'(1);
      end
      ACT_HLINE: begin
        seg_count = SEG_W'(1);
      end
      ACT_VLINE: begin
        seg_horiz_next = 1'b0;
        seg_count      = SEG_W'(1);
      end
      ACT_RECT: begin
        if (cmd_fields.rect_width == '0 || cmd_fields.rect_height == '0) begin
          seg_count = '0;
        end else if (cmd_fields.rect_height < RSIZE_W'(3)) begin
          seg_count = SEG_W'(2);
        end else begin
          seg_count = SEG_W'(4);
        end
        case (seg)
          SEG_W'(0): begin
            seg_len_next = LEN_W'(cmd_fields.rect_width);
          end
          SEG_W'(1): begin
            seg_y_next   = COORD_W'(cmd_fields.y_pos) + COORD_W'(cmd_fields.rect_height)
                           - COORD_W'(1);
            seg_len_next = LEN_W'(cmd_fields.rect_width);
          end
          SEG_W'(2): begin
            seg_y_next     = COORD_W'(cmd_fields.y_pos) + COORD_W'(1);
            seg_len_next   = LEN_W'(cmd_fields.rect_height) - LEN_W'(2);
            seg_horiz_next = 1'b0;
          end
          default: begin
            seg_x_next     = COORD_W'(cmd_fields.x_pos) + COORD_W'(cmd_fields.rect_width)
                             - COORD_W'(1);
            seg_y_next     = COORD_W'(cmd_fields.y_pos) + COORD_W'(1);
            seg_len_next   = LEN_W'(cmd_fields.rect_height) - LEN_W'(2);
            seg_horiz_next = 1'b0;
          end
        endcase
      end
      default: begin
        seg_count = '0;
      end
    endcase
  end

  assign thick_last = (cnt_t == seg_thick - THICK_W'(1));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      seg <= '0;
    end else if (cmd.seg_next) begin
      seg <= seg + SEG_W'(1);
    end
    if (cmd.seg_load) begin
      seg_x     <= seg_x_next;
      seg_y     <= seg_y_next;
      seg_len   <= seg_len_next;
      seg_thick <= seg_thick_next;
      seg_horiz <= seg_horiz_next;
      cnt_a     <= '0;
      cnt_t     <= '0;
    end else if (cmd.step) begin
      if (thick_last) begin
        cnt_t <= '0;
        cnt_a <= cnt_a + LEN_W'(1);
      end else begin
        cnt_t <= cnt_t + THICK_W'(1);
      end
    end
  end

  // Pixel position, frame test and byte address.
  always_comb begin
    px       = seg_horiz ? seg_x + COORD_W'(cnt_a) : seg_x + COORD_W'(cnt_t);
    py       = seg_horiz ? seg_y + COORD_W'(cnt_t) : seg_y + COORD_W'(cnt_a);
    in_frame = (32'(px) < 32'(eff_w)) && (32'(py) < 32'(eff_h));
    lin_addr = PROD_W'(px >> 3) + PROD_W'(py) * PROD_W'(row_bytes);
  end

  always_ff @(posedge clk) begin
    if (cmd.pix_calc) begin
      pix_addr    <= lin_addr[ADDR_W-1:0];
      pix_mask    <= PIXEL_MSB >> px[2:0];
      pix_outside <= !in_frame || (32'(lin_addr) >= STORE_BYTES);
    end
  end

  assign fill_prod = (ROWB_W+EFFH_W)'(row_bytes) * (ROWB_W+EFFH_W)'(eff_h);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.fill_init) begin
      count <= '0;
    end else if (cmd.clear_write || cmd.fill_write) begin
      count <= count + COUNT_W'(1);
    end
    if (cmd.fill_init) begin
      fill_total <= (32'(fill_prod) > STORE_BYTES) ? COUNT_W'(STORE_BYTES)
                                                   : COUNT_W'(fill_prod);
    end
  end

  always_comb begin
    mem_we    = cmd.clear_write || cmd.fill_write || cmd.pix_write;
    mem_waddr = cmd.pix_write ? pix_addr : count[ADDR_W-1:0];
    if (cmd.pix_write) begin
      mem_wdata = draw_color ? (mem_rdata | pix_mask) : (mem_rdata & ~pix_mask);
    end else if (cmd.fill_write) begin
      mem_wdata = draw_color ? FILL_ONES : FILL_ZEROS;
    end else begin
      mem_wdata = FILL_ZEROS;
    end
    mem_re    = cmd.pix_read || cmd.idx_read;
    mem_raddr = cmd.idx_read ? ADDR_W'(cmd_fields.read_index) : pix_addr;
    idx_ok    = (32'(cmd_fields.read_index) < STORE_BYTES);
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      clip    <= 1'b0;
      rd_byte <= '0;
    end else begin
      if (cmd.mark_clip || (cmd.read_capture && !idx_ok)) begin
        clip <= 1'b1;
      end
      if (cmd.read_capture) begin
        rd_byte <= idx_ok ? mem_rdata : FILL_ZEROS;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (cmd.out_load) begin
      m_tdata <= rd_byte;
      m_tuser <= clip;
    end
  end

  always_comb begin
    status.action      = cmd_action;
    status.clear_last  = (count == COUNT_W'(STORE_BYTES - 1));
    status.fill_done   = (count >= fill_total);
    status.seg_done    = (seg == seg_count);
    status.seg_empty   = (seg_len == '0) || (seg_thick == '0);
    status.pix_outside = pix_outside;
    status.pix_last    = thick_last && (cnt_a == seg_len - LEN_W'(1));
    status.out_free    = !m_tvalid || m_tready;
  end

endmodule

/* hdl/mono_framebuffer_draw_engine.sv */
// ----------------------------------------------------------------------------
// mono_framebuffer_draw_engine
// Drawing engine for a one-bit-per-pixel, MSB-first, row-major frame store.
// ----------------------------------------------------------------------------
// The command stream carries one drawing command per transfer: the action in
// s_tuser and its operands in s_tdata. Each command produces exactly one
// result transfer on the master side: the byte read back (zero for drawing
// commands) in m_tdata and the clipped flag in m_tuser. The user must write
// registers through the cfg port between commands; the block does not
// enforce it. Commands run one at a time. A pixel inside the frame goes
// through address calculation, a frame test with read and a write back; a
// pixel outside the frame stops after the frame test. A fill writes one
// byte per cycle, a read addresses the store and then captures the byte,
// and each command also passes through decode and result hand-off.
// After reset the store is cleared to zero, one byte per cycle, all 8192
// bytes; s_tready stays low until that pass is done.
// The result is held in an output register, so a new command is accepted
// while the previous result waits; if the receiver stalls, the next result
// waits until the output register is free.
// ----------------------------------------------------------------------------
module mono_framebuffer_draw_engine (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [mfd_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [mfd_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // x_pos, y_pos, length, rect_width, rect_height, read_index, zero pad.
  input  logic [mfd_pkg::S_TDATA_W-1:0]    s_tdata,
  // action.
  input  logic [mfd_pkg::S_TUSER_W-1:0]    s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // read_data.
  output logic [mfd_pkg::M_TDATA_W-1:0]    m_tdata,
  // clipped.
  output logic                             m_tuser
);
  import mfd_pkg::*;

  cmd_t    cmd;
  status_t status;

  mfd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  mfd_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

/* hdl/mfd_checker.sv */
// ----------------------------------------------------------------------------
// mfd_checker
// Port-level checks of the draw engine, bound to the top level.
// ----------------------------------------------------------------------------
module mfd_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [mfd_pkg::M_TDATA_W-1:0] m_tdata,
  input logic                          m_tuser
);
  import mfd_pkg::*;

  // The store clearing pass holds off commands right after reset.
  a_ready_low_after_reset: assert property (@(posedge clk) rst |=> !s_tready)
    else $error("command accepted during the store clearing pass");

  a_no_result_after_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result pending right after reset");

  // Commands run one at a time, so an accepted transfer closes the input.
  a_one_command_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second command accepted before the first completed");

  a_result_held_on_stall: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("result changed or dropped while stalled");

endmodule

bind mono_framebuffer_draw_engine mfd_checker u_mfd_checker (.*);

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the monochrome frame buffer draw engine. A shadow
// frame store in the checker class replays every accepted command and queues
// the byte and clipped flag it should return. Directed commands cover frame
// edges, rectangle shapes, fills and unused actions. Random phases then run
// under new register settings, with bursty command traffic, receiver stalls
// and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb;
  import mfd_pkg::*;

  localparam logic [ACTION_W-1:0] ACT_SPARE_A = 3'd6;
  localparam logic [ACTION_W-1:0] ACT_SPARE_B = 3'd7;
  localparam int HOLD_CYCLES = 3000;
  localparam longint unsigned BASE_LIMIT = 200000;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              clipped;
  } draw_result_t;

  class draw_checker;
    logic [DATA_W-1:0]  shadow_store [STORE_BYTES];
    logic [DIM_W-1:0]   frame_w;
    logic [DIM_W-1:0]   frame_h;
    logic [THICK_W-1:0] thick;
    logic               color;
    draw_result_t       pending_results [$];
    int unsigned        errors;
    longint unsigned    budget;
    int unsigned        pixel_visits;

    function new();
      foreach (shadow_store[i]) shadow_store[i] = FILL_ZEROS;
      frame_w = RST_FRAME_WIDTH;
      frame_h = RST_FRAME_HEIGHT;
      thick = RST_THICKNESS;
      color = RST_DRAW_COLOR;
      errors = 0;
      budget = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_FRAME_WIDTH:    frame_w = value;
        CFG_FRAME_HEIGHT:   frame_h = value;
        CFG_LINE_THICKNESS: thick = value[THICK_W-1:0];
        CFG_DRAW_COLOR:     color = value[0];
        default: ;
      endcase
    endfunction

    function int unsigned eff_w();
      return (frame_w > MAX_WIDTH) ? MAX_WIDTH : frame_w;
    endfunction

    function int unsigned eff_h();
      return (frame_h > MAX_HEIGHT) ? MAX_HEIGHT : frame_h;
    endfunction

    function bit plot(int unsigned x, int unsigned y);
      int unsigned w;
      int unsigned h;
      int unsigned addr;
      logic [DATA_W-1:0] mask;
      w = eff_w();
      h = eff_h();
      pixel_visits++;
      if (x >= w || y >= h) return 1'b1;
      addr = (x >> 3) + y * ((w + 7) >> 3);
      if (addr >= STORE_BYTES) return 1'b1;
      mask = PIXEL_MSB >> (x & 7);
      if (color) shadow_store[addr] = shadow_store[addr] | mask;
      else shadow_store[addr] = shadow_store[addr] & ~mask;
      return 1'b0;
    endfunction

    function bit line(int unsigned x, int unsigned y, int unsigned len, bit horiz);
      bit clip;
      int unsigned a;
      int unsigned t;
      clip = 1'b0;
      for (a = 0; a < len; a++) begin
        for (t = 0; t < thick; t++) begin
          if (horiz) clip = plot(x + a, y + t) | clip;
          else clip = plot(x + t, y + a) | clip;
        end
      end
      return clip;
    endfunction

    function bit rect(int unsigned x, int unsigned y, int unsigned w, int unsigned h);
      bit clip;
      clip = 1'b0;
      if (w == 0 || h == 0) return 1'b0;
      clip = line(x, y, w, 1'b1) | clip;
      clip = line(x, y + h - 1, w, 1'b1) | clip;
      if (h >= 3) begin
        clip = line(x, y + 1, h - 2, 1'b0) | clip;
        clip = line(x + w - 1, y + 1, h - 2, 1'b0) | clip;
      end
      return clip;
    endfunction

    function void fill();
      int unsigned total;
      int unsigned i;
      total = ((eff_w() + 7) >> 3) * eff_h();
      if (total > STORE_BYTES) total = STORE_BYTES;
      for (i = 0; i < total; i++) shadow_store[i] = color ? FILL_ONES : FILL_ZEROS;
      budget += total;
    endfunction

    function void take_command(logic [ACTION_W-1:0] act, in_fields_t f);
      draw_result_t r;
      r = '0;
      pixel_visits = 0;
      case (act)
        ACT_PIXEL: r.clipped = plot(f.x_pos, f.y_pos);
        ACT_HLINE: r.clipped = line(f.x_pos, f.y_pos, f.length, 1'b1);
        ACT_VLINE: r.clipped = line(f.x_pos, f.y_pos, f.length, 1'b0);
        ACT_RECT:  r.clipped = rect(f.x_pos, f.y_pos, f.rect_width, f.rect_height);
        ACT_FILL:  fill();
        ACT_READ: begin
          if (f.read_index < STORE_BYTES) r.read_data = shadow_store[f.read_index];
          else r.clipped = 1'b1;
        end
        default: ;
      endcase
      budget += 3 * longint'(pixel_visits) + 80;
      pending_results.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("mismatch: %s", msg);
    endtask

    task check_result(logic [DATA_W-1:0] data, logic clip);
      draw_result_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("result transfer with nothing expected, data %02h", data));
        return;
      end
      want = pending_results.pop_front();
      if (data !== want.read_data)
        report($sformatf("read_data got %02h expected %02h", data, want.read_data));
      if (clip !== want.clipped)
        report($sformatf("clipped got %b expected %b", clip, want.clipped));
    endtask
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = CFG_FRAME_WIDTH;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [S_TDATA_W-1:0]   s_tdata = '0;
  logic [S_TUSER_W-1:0]   s_tuser = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b1;
  logic [M_TDATA_W-1:0]   m_tdata;
  logic                   m_tuser;

  draw_checker     chk;
  longint unsigned cycles = 0;
  bit              rx_mode = 1'b0;
  bit              hold_toggle = 1'b0;
  bit              hold_seen = 1'b0;
  int              hold_left = 0;
  int              run_left = 0;
  int              stall_left = 0;

  mono_framebuffer_draw_engine u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (chk != null && cycles > 4 * chk.budget + BASE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) chk.check_result(m_tdata, m_tuser);
    if (hold_toggle != hold_seen) begin
      hold_seen = hold_toggle;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (!rx_mode) begin
      m_tready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (run_left != 0) begin
      run_left--;
      m_tready <= 1'b1;
    end else begin
      run_left = $urandom_range(0, 11);
      stall_left = $urandom_range(1, 10);
      m_tready <= 1'b1;
    end
  end

  task automatic send_cmd(input logic [ACTION_W-1:0] act, input in_fields_t f);
    s_tvalid <= 1'b1;
    s_tuser <= act;
    s_tdata <= S_TDATA_W'(f);
    do @(posedge clk); while (!s_tready);
    chk.take_command(act, f);
  endtask

  task automatic issue(input logic [ACTION_W-1:0] act, input int x, input int y,
                       input int len, input int rw, input int rh, input int idx);
    in_fields_t f;
    f.x_pos = POS_W'(x);
    f.y_pos = POS_W'(y);
    f.length = LEN_W'(len);
    f.rect_width = RSIZE_W'(rw);
    f.rect_height = RSIZE_W'(rh);
    f.read_index = IDX_W'(idx);
    send_cmd(act, f);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (chk.pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_frame(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                           input logic [THICK_W-1:0] th, input logic color);
    cfg_we <= 1'b1;
    cfg_index <= CFG_FRAME_WIDTH;
    cfg_data <= w;
    @(posedge clk);
    cfg_index <= CFG_FRAME_HEIGHT;
    cfg_data <= h;
    @(posedge clk);
    cfg_index <= CFG_LINE_THICKNESS;
    cfg_data <= CFG_DATA_W'(th);
    @(posedge clk);
    cfg_index <= CFG_DRAW_COLOR;
    cfg_data <= CFG_DATA_W'(color);
    @(posedge clk);
    cfg_we <= 1'b0;
    chk.write_reg(CFG_FRAME_WIDTH, w);
    chk.write_reg(CFG_FRAME_HEIGHT, h);
    chk.write_reg(CFG_LINE_THICKNESS, CFG_DATA_W'(th));
    chk.write_reg(CFG_DRAW_COLOR, CFG_DATA_W'(color));
  endtask

  function automatic logic [DIM_W-1:0] pick_dim();
    case ($urandom_range(0, 11))
      0: return DIM_W'(0);
      1: return DIM_W'(1);
      2: return DIM_W'(8);
      3: return DIM_W'(9);
      4: return DIM_W'(256);
      5: return DIM_W'($urandom_range(257, 511));
      default: return DIM_W'($urandom_range(2, 256));
    endcase
  endfunction

  function automatic logic [THICK_W-1:0] pick_thick();
    case ($urandom_range(0, 7))
      0: return THICK_W'(0);
      1: return THICK_W'($urandom_range(4, 10));
      default: return THICK_W'($urandom_range(1, 3));
    endcase
  endfunction

  function automatic void make_random_cmd(output logic [ACTION_W-1:0] act,
                                          output in_fields_t f);
    int unsigned w;
    int unsigned h;
    int unsigned pick;
    int unsigned px;
    int unsigned py;
    w = chk.eff_w();
    h = chk.eff_h();
    pick = $urandom_range(0, 99);
    f.x_pos = POS_W'((w != 0 && $urandom_range(0, 3) != 0) ?
                     $urandom_range(0, w - 1) : $urandom_range(0, 255));
    f.y_pos = POS_W'((h != 0 && $urandom_range(0, 3) != 0) ?
                     $urandom_range(0, h - 1) : $urandom_range(0, 255));
    f.length = LEN_W'(($urandom_range(0, 19) == 0) ?
                      $urandom_range(0, 511) : $urandom_range(0, 24));
    f.rect_width = RSIZE_W'(($urandom_range(0, 9) == 0) ?
                            $urandom_range(0, 255) : $urandom_range(0, 16));
    f.rect_height = RSIZE_W'(($urandom_range(0, 9) == 0) ?
                             $urandom_range(0, 255) : $urandom_range(0, 16));
    if (w != 0 && h != 0 && $urandom_range(0, 1) != 0) begin
      px = $urandom_range(0, w - 1);
      py = $urandom_range(0, h - 1);
      f.read_index = IDX_W'((px >> 3) + py * ((w + 7) >> 3));
    end else begin
      f.read_index = IDX_W'($urandom_range(0, 8191));
    end
    if (pick < 18) act = ACT_PIXEL;
    else if (pick < 32) act = ACT_HLINE;
    else if (pick < 46) act = ACT_VLINE;
    else if (pick < 60) act = ACT_RECT;
    else if (pick < 62) act = ACT_FILL;
    else if (pick < 65) act = $urandom_range(0, 1) ? ACT_SPARE_A : ACT_SPARE_B;
    else act = ACT_READ;
  endfunction

  task automatic random_phase(input int count, input int gap_max);
    logic [ACTION_W-1:0] act;
    in_fields_t f;
    int burst_left;
    int gap;
    int n;
    burst_left = 0;
    for (n = 0; n < count; n++) begin
      make_random_cmd(act, f);
      send_cmd(act, f);
      if (burst_left != 0) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(0, 19);
        gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
        if (gap != 0) begin
          s_tvalid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  endtask

  initial begin
    int ph;
    int gap_max;
    chk = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    do @(posedge clk); while (!s_tready);

    issue(ACT_READ, 0, 0, 0, 0, 0, 0);
    issue(ACT_READ, 0, 0, 0, 0, 0, 8191);
    issue(ACT_PIXEL, 0, 0, 0, 0, 0, 0);
    issue(ACT_PIXEL, 199, 199, 0, 0, 0, 0);
    issue(ACT_PIXEL, 200, 0, 0, 0, 0, 0);
    issue(ACT_PIXEL, 255, 255, 0, 0, 0, 0);
    issue(ACT_HLINE, 190, 5, 20, 0, 0, 0);
    issue(ACT_VLINE, 7, 190, 15, 0, 0, 0);
    issue(ACT_RECT, 10, 10, 0, 5, 1, 0);
    issue(ACT_RECT, 20, 20, 0, 5, 2, 0);
    issue(ACT_RECT, 30, 30, 0, 6, 3, 0);
    issue(ACT_RECT, 40, 40, 0, 0, 5, 0);
    issue(ACT_RECT, 40, 40, 0, 5, 0, 0);
    issue(ACT_READ, 0, 0, 0, 0, 0, 0);
    issue(ACT_SPARE_A, 255, 255, 511, 255, 255, 8191);
    issue(ACT_SPARE_B, 255, 255, 511, 255, 255, 8191);
    drain();

    set_frame(DIM_W'(511), DIM_W'(511), THICK_W'(1), 1'b1);
    issue(ACT_HLINE, 0, 255, 511, 0, 0, 0);
    issue(ACT_FILL, 0, 0, 0, 0, 0, 0);
    issue(ACT_READ, 0, 0, 0, 0, 0, 8191);
    drain();

    set_frame(DIM_W'(0), DIM_W'(256), THICK_W'(255), 1'b0);
    issue(ACT_PIXEL, 0, 0, 0, 0, 0, 0);
    issue(ACT_FILL, 0, 0, 0, 0, 0, 0);
    issue(ACT_VLINE, 0, 0, 1, 0, 0, 0);
    issue(ACT_READ, 0, 0, 0, 0, 0, 0);
    drain();

    set_frame(DIM_W'(256), DIM_W'(1), THICK_W'(0), 1'b0);
    issue(ACT_HLINE, 0, 0, 10, 0, 0, 0);
    issue(ACT_PIXEL, 255, 0, 0, 0, 0, 0);
    issue(ACT_READ, 0, 0, 0, 0, 0, 31);
    drain();

    set_frame(DIM_W'(9), DIM_W'(256), THICK_W'(255), 1'b1);
    issue(ACT_HLINE, 0, 0, 9, 0, 0, 0);
    issue(ACT_READ, 0, 0, 0, 0, 0, 3);
    drain();

    for (ph = 0; ph < 8; ph++) begin
      set_frame(pick_dim(), pick_dim(), pick_thick(), 1'(($urandom_range(0, 1))));
      rx_mode <= (ph != 0 && ph != 2);
      gap_max = (ph == 0 || ph == 2) ? 0 : ((ph == 4) ? 3 : 12);
      if (ph == 2) hold_toggle <= ~hold_toggle;
      random_phase(68, gap_max);
      drain();
    end

    repeat (50) @(posedge clk);
    if (chk.errors == 0 && chk.pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
